// ===== design/ktt_pkg.sv =====
// Package for the k-th largest tracker: sizes, request codes, FSM states
// and the link record passed between neighboring sorted cells.
// No dependencies; every other file in this block imports it.
package ktt_pkg;

  localparam int K_MAX     = 256;
  localparam int VAL_W     = 64;
  localparam int RANK_W    = 9;
  localparam int REQ_W     = 2;
  localparam int CNT_W     = $clog2(K_MAX + 1);
  localparam int CMP_W     = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Read tree: groups of GRP_SIZE cells are narrowed first, then the group.
  localparam int GRP_SIZE  = 16;
  localparam int GRP_SEL_W = $clog2(GRP_SIZE);
  localparam int NUM_GRP   = (K_MAX + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_IDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int RD_IDX_W  = GRP_SEL_W + GRP_IDX_W;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_GRP,
    S_RD_SEL,
    S_OUT
  } state_t;

  // What one cell shows its lower neighbor.
  typedef struct packed {
    val_t value;
    logic ge;
  } cell_link_t;

endpackage

// ===== design/ktt_if.sv =====
// Request and result channel interfaces for the k-th largest tracker.
// Depends on ktt_pkg for field widths.
interface ktt_req_if import ktt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] insert_value;

  modport source (output valid, output req_type, output insert_value, input ready);
  modport sink   (input valid, input req_type, input insert_value, output ready);
endinterface

interface ktt_res_if import ktt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] kth_value;
  logic                    found;

  modport source (output valid, output kth_value, output found, input ready);
  modport sink   (input valid, input kth_value, input found, output ready);
endinterface

// ===== design/ktt_cell.sv =====
// One cell of the descending sorted chain: holds one value and shifts or
// captures on an insert. Depends on ktt_pkg.
module ktt_cell import ktt_pkg::*; (
  input  logic       clk,
  input  logic       ins_en,
  input  logic       in_use,
  input  val_t       new_value,
  input  cell_link_t prev,
  output cell_link_t link
);

  val_t value;
  logic ge;

  // A cell keeps its value when it is at least the new one; otherwise the
  // first such cell takes the new value and all below it shift down by one.
  assign ge = in_use && (value >= new_value);

  always_ff @(posedge clk) begin
    if (ins_en && !ge) begin
      value <= prev.ge ? new_value : prev.value;
    end
  end

  assign link.value = value;
  assign link.ge    = ge;

endmodule

// ===== design/ktt_rdtree.sv =====
// Two-stage registered read tree that picks one cell value by index.
// Depends on ktt_pkg.
module ktt_rdtree import ktt_pkg::*; (
  input  logic                clk,
  input  logic                grp_en,
  input  logic                sel_en,
  input  logic [RD_IDX_W-1:0] rd_idx,
  input  val_t                vals [K_MAX],
  output val_t                rd_data
);

  logic [GRP_SEL_W-1:0] lo;
  logic [GRP_IDX_W-1:0] hi;
  logic [GRP_IDX_W-1:0] hi_q;
  val_t                 grp_q [NUM_GRP];

  assign lo = rd_idx[GRP_SEL_W-1:0];
  assign hi = rd_idx[RD_IDX_W-1:GRP_SEL_W];

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    val_t ent [GRP_SIZE];
    for (genvar j = 0; j < GRP_SIZE; j++) begin : g_ent
      if (g * GRP_SIZE + j < K_MAX) begin : g_real
        assign ent[j] = vals[g * GRP_SIZE + j];
      end else begin : g_pad
        assign ent[j] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (grp_en) begin
        grp_q[g] <= ent[lo];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_en) begin
      hi_q <= hi;
    end
    if (sel_en) begin
      rd_data <= grp_q[hi_q];
    end
  end

endmodule

// ===== design/kth_largest_tracker_core.sv =====
// Top level of the k-th largest tracker: sorted cell chain, read tree,
// control FSM and output register. Depends on ktt_pkg, ktt_if, ktt_cell, ktt_rdtree.
//
// Usage:
//   Requests arrive on req (valid/ready). An insert puts insert_value into a
//   chain of K_MAX cells kept in descending order; every cell compares in
//   parallel and the smaller ones shift down together.
//   When the chain is full the smallest value falls off the end. A clear
//   request empties the chain. Inserts and clears give no result.
//   A query reads the cell at rank kth_rank through a two-stage registered
//   read tree and returns kth_value and found on res; found is 0 (and
//   kth_value zero) when kth_rank is zero or above the number of stored values.
//   After a query is accepted, req.ready stays low through the two read tree
//   stages and the load of the output register; the result shows on res in
//   the cycle after that, so a new request is taken only once the query's result is loaded.
//   Request code three is accepted and dropped.
//   If the receiver stalls, the result waits in the output register; inserts
//   and clears are still taken, and a following query finishes its read and
//   then waits until the register is free.
//   kth_rank is written through cfg_we/cfg_wdata; the user must write it only
//   while the block is idle, which the block does not enforce. Reset (rst,
//   synchronous) empties the chain, sets kth_rank to 1 and drops any pending result.
module kth_largest_tracker_core import ktt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ktt_req_if.sink           req,
  ktt_res_if.source         res,
  input  logic              cfg_we,
  input  logic [RANK_W-1:0] cfg_wdata
);

  state_t              state;
  state_t              state_next;
  logic [RANK_W-1:0]   kth_rank;
  logic [CNT_W-1:0]    stored_count;
  logic                accept;
  logic                ins_en;
  logic                hit;
  logic                hit_q;
  logic [RD_IDX_W-1:0] rd_idx;
  logic                grp_en;
  logic                sel_en;
  logic                out_load;
  logic                res_valid;
  val_t                res_value;
  logic                res_found;
  val_t                rd_data;
  val_t                vals [K_MAX];
  cell_link_t          links [K_MAX];

  assign accept = req.valid && req.ready;
  assign ins_en = accept && (req.req_type == REQ_INSERT);
  assign hit    = (kth_rank != '0) && (CMP_W'(kth_rank) <= CMP_W'(stored_count));

  // Sorted chain. The cell above the first one acts as plus infinity.
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    cell_link_t prev;
    if (i == 0) begin : g_head
      assign prev = '{value: '0, ge: 1'b1};
    end else begin : g_body
      assign prev = links[i-1];
    end

    ktt_cell u_cell (
      .clk       (clk),
      .ins_en    (ins_en),
      .in_use    (CNT_W'(i) < stored_count),
      .new_value (req.insert_value),
      .prev      (prev),
      .link      (links[i])
    );

    assign vals[i] = links[i].value;
  end

  ktt_rdtree u_rdtree (
    .clk     (clk),
    .grp_en  (grp_en),
    .sel_en  (sel_en),
    .rd_idx  (rd_idx),
    .vals    (vals),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      kth_rank     <= RANK_W'(1);
      stored_count <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        kth_rank <= cfg_wdata;
      end
      if (accept && (req.req_type == REQ_CLEAR)) begin
        stored_count <= '0;
      end else if (ins_en && (stored_count != CNT_W'(K_MAX))) begin
        stored_count <= stored_count + CNT_W'(1);
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.req_type == REQ_QUERY)) begin
      hit_q  <= hit;
      rd_idx <= RD_IDX_W'(kth_rank - RANK_W'(1));
    end
    if (out_load) begin
      res_value <= hit_q ? rd_data : '0;
      res_found <= hit_q;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (req.req_type == REQ_QUERY)) begin
          state_next = S_RD_GRP;
        end
      end
      S_RD_GRP: state_next = S_RD_SEL;
      S_RD_SEL: state_next = S_OUT;
      S_OUT: begin
        if (!res_valid || res.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    grp_en    = 1'b0;
    sel_en    = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE:   req.ready = 1'b1;
      S_RD_GRP: grp_en    = 1'b1;
      S_RD_SEL: sel_en    = 1'b1;
      S_OUT:    out_load  = !res_valid || res.ready;
      default: begin
      end
    endcase
  end

  assign res.valid     = res_valid;
  assign res.kth_value = res_value;
  assign res.found     = res_found;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(stored_count) <= CMP_W'(K_MAX))
    else $error("stored count exceeds chain length");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (ins_en && (stored_count != CNT_W'(K_MAX)) && !cfg_we)
      |=> (stored_count == $past(stored_count) + CNT_W'(1)))
    else $error("insert into a chain with room did not grow the count");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (K_MAX > 1 && CMP_W'(stored_count) >= CMP_W'(2))
      |-> (vals[0] >= vals[K_MAX > 1 ? 1 : 0]))
    else $error("first two cells out of order");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the output load step");

endmodule

// ===== tb/tb_kth_largest_tracker_core.sv =====
// Testbench for kth_largest_tracker_core: random and directed requests, with
// an in-bench sorted-store predictor checked against every query result.
// Depends on ktt_pkg, ktt_if and the kth_largest_tracker_core RTL.
module tb_kth_largest_tracker_core import ktt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam val_t VAL_TOP    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam val_t VAL_BOTTOM = 64'sh8000_0000_0000_0000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    val_t kth_value;
    logic found;
  } rank_answer_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [RANK_W-1:0] cfg_wdata;

  ktt_req_if req_ch ();
  ktt_res_if res_ch ();

  kth_largest_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted store: largest first, only held_count entries are meaningful.
  val_t sorted_vals [K_MAX];
  int held_count = 0;
  int rank_cfg = 1;
  rank_answer_t pending_answers [$];

  int fail_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int stall_orders = 0;
  int stuck_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_request(input logic [REQ_W-1:0] code, input val_t value);
    rank_answer_t ans;
    int pos;
    int last;
    int i;
    if (code == REQ_INSERT) begin
      pos = 0;
      // Equal values already held stay ahead of the new copy.
      while (pos < held_count && sorted_vals[pos] >= value) pos++;
      if (pos < K_MAX) begin
        if (held_count < K_MAX) begin
          last = held_count;
          held_count++;
        end else begin
          last = K_MAX - 1;
        end
        for (i = last; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = value;
      end
    end else if (code == REQ_QUERY) begin
      if (rank_cfg >= 1 && rank_cfg <= held_count) begin
        ans.kth_value = sorted_vals[rank_cfg-1];
        ans.found = 1'b1;
      end else begin
        ans.kth_value = '0;
        ans.found = 1'b0;
      end
      pending_answers.push_back(ans);
    end else if (code == REQ_CLEAR) begin
      held_count = 0;
    end
  endfunction

  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_TOP;
      1: return VAL_BOTTOM;
      2: return val_t'(int'($urandom_range(0, 2)) - 1);
      3, 4, 5: return val_t'(int'($urandom_range(0, 16)) - 8);
      6, 7: return val_t'(int'($urandom()));
      default: return val_t'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_code(input int clear_permille);
    int r;
    r = $urandom_range(0, 999);
    if (r < clear_permille) return REQ_CLEAR;
    if (r < 2 * clear_permille + 10) return REQ_RESERVED;
    if (r < 730) return REQ_INSERT;
    return REQ_QUERY;
  endfunction

  // Offer one request and return in the time step where it was accepted.
  task automatic send_request(input logic [REQ_W-1:0] code, input val_t value);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= code;
    req_ch.insert_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_request(code, value);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rank(input logic [RANK_W-1:0] k);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    rank_cfg = k;
  endtask

  task automatic run_random_phase(input logic [RANK_W-1:0] k, input int n_items,
                                  input int clear_permille);
    write_rank(k);
    repeat (n_items) send_request(pick_code(clear_permille), pick_value());
  endtask

  task automatic test_directed_cases();
    send_request(REQ_QUERY, '0);
    send_request(REQ_INSERT, 64'sd0);
    send_request(REQ_INSERT, -64'sd1);
    send_request(REQ_INSERT, VAL_TOP);
    send_request(REQ_INSERT, VAL_BOTTOM);
    send_request(REQ_INSERT, VAL_TOP);
    send_request(REQ_QUERY, '0);
    send_request(REQ_RESERVED, VAL_TOP);
    send_request(REQ_QUERY, VAL_BOTTOM);
    write_rank(9'd0);
    send_request(REQ_QUERY, '0);
    write_rank(9'd5);
    send_request(REQ_QUERY, '0);
    write_rank(9'd6);
    send_request(REQ_QUERY, '0);
    write_rank(9'd511);
    send_request(REQ_QUERY, '0);
    write_rank(9'd2);
    send_request(REQ_QUERY, '0);
    send_request(REQ_CLEAR, VAL_TOP);
    send_request(REQ_QUERY, '0);
    send_request(REQ_INSERT, 64'sh5555_AAAA_5555_AAAA);
    send_request(REQ_INSERT, 64'sh5555_AAAA_5555_AAAA);
    send_request(REQ_QUERY, '0);
  endtask

  // Enough inserts to fill the store, so the smallest values start to fall off.
  task automatic test_fill_and_overflow();
    run_random_phase(9'd1, 200, 0);
    run_random_phase(9'd256, 300, 0);
  endtask

  task automatic test_rank_extremes();
    run_random_phase(9'd0, 100, 0);
    run_random_phase(9'd511, 80, 0);
    run_random_phase(9'd257, 80, 0);
  endtask

  task automatic test_random_ranks();
    run_random_phase(RANK_W'($urandom_range(1, 256)), 250, 10);
    run_random_phase(9'd2, 200, 3);
  endtask

  // The receiver holds off while the sender keeps offering, so the block's
  // input stalls behind a pending query; then the sender waits for all results and sends 40 more requests.
  task automatic test_backpressure();
    int n;
    write_rank(9'd3);
    stall_orders++;
    for (n = 0; n < 80; n++)
      send_request(($urandom_range(0, 99) < 40) ? REQ_QUERY : REQ_INSERT, pick_value());
    wait_drained();
    repeat (40) send_request(pick_code(5), pick_value());
  endtask

  task automatic test_steady_stream();
    run_random_phase(9'd128, 200, 0);
    run_random_phase(RANK_W'($urandom_range(1, 256)), 200, 5);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.insert_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 8;
    sink_idle_pct = 65;
    test_directed_cases();
    test_fill_and_overflow();
    test_rank_extremes();

    src_idle_pct = 65;
    sink_idle_pct = 8;
    test_random_ranks();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_steady_stream();

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side ready: random idling, or a long hold-off when one is ordered.
  initial begin
    int stall_left;
    int stalls_served;
    stall_left = 0;
    stalls_served = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served != stall_orders) begin
        stalls_served = stall_orders;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    rank_answer_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: kth_value %0d found %0b", res_ch.kth_value, res_ch.found);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (res_ch.kth_value !== want.kth_value) begin
          $error("kth_value mismatch: expected %0d, actual %0d", want.kth_value,
                 res_ch.kth_value);
          fail_count++;
        end
        if (res_ch.found !== want.found) begin
          $error("found mismatch: expected %0b, actual %0b", want.found, res_ch.found);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || cfg_we === 1'b1) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
